[design/ccs_pkg.sv]
package ccs_pkg;

    localparam int SYM_FIELDS  = 8;
    localparam int CHIP_LIMIT  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int USER_CNT_W  = 4;
    localparam int CODE_LEN_W  = 5;
    localparam int CHIP_IDX_W  = 4;
    localparam int SUM_W       = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_USER_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_LENGTH = 2'd1;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SPREAD = 1'b1;

    localparam logic [USER_CNT_W-1:0] USER_COUNT_RST  = 4'd8;
    localparam logic [CODE_LEN_W-1:0] CODE_LENGTH_RST = 5'd16;

    // -2 saturates to -1
    function automatic logic [1:0] sat_trit(input logic [1:0] raw);
        logic [1:0] res;
        res = (raw == 2'b10) ? 2'b11 : raw;
        return res;
    endfunction

    // product of two saturated trits, -1..1
    function automatic logic [1:0] trit_mul(input logic [1:0] a, input logic [1:0] b);
        logic [1:0] res;
        if (a == 2'b00 || b == 2'b00) begin
            res = 2'b00;
        end else if (a[1] ^ b[1]) begin
            res = 2'b11;
        end else begin
            res = 2'b01;
        end
        return res;
    endfunction

endpackage

[design/ccs_if.sv]
interface ccs_in_if;
    logic              valid;
    logic              ready;
    logic              func;
    logic        [2:0] code_user;
    logic        [3:0] code_chip;
    logic signed [1:0] code_value;
    logic signed [1:0] bit_0;
    logic signed [1:0] bit_1;
    logic signed [1:0] bit_2;
    logic signed [1:0] bit_3;
    logic signed [1:0] bit_4;
    logic signed [1:0] bit_5;
    logic signed [1:0] bit_6;
    logic signed [1:0] bit_7;

    modport source (
        output valid, func, code_user, code_chip, code_value,
               bit_0, bit_1, bit_2, bit_3, bit_4, bit_5, bit_6, bit_7,
        input  ready
    );
    modport sink (
        input  valid, func, code_user, code_chip, code_value,
               bit_0, bit_1, bit_2, bit_3, bit_4, bit_5, bit_6, bit_7,
        output ready
    );
endinterface

interface ccs_out_if;
    logic              valid;
    logic              ready;
    logic        [3:0] chip_index;
    logic signed [4:0] chip_sum;
    logic              last_chip;

    modport source (output valid, chip_index, chip_sum, last_chip, input ready);
    modport sink   (input valid, chip_index, chip_sum, last_chip, output ready);
endinterface

interface ccs_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [4:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/ccs_code_mem.sv]
module ccs_code_mem #(
    parameter int ROWS   = 16,
    parameter int ROW_W  = 4,
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ROW_W-1:0]  i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ROW_W-1:0]  i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [ROWS];
    logic [ROWS-1:0]   r_row_vld;
    logic [DATA_W-1:0] r_q;
    logic              r_q_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    // rows never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_q_vld   <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_q_vld <= r_row_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_q_vld ? r_q : '0;

endmodule

[design/ccs_chip_sum.sv]
module ccs_chip_sum
    import ccs_pkg::*;
#(
    parameter int LANES = 8
) (
    input  logic [LANES*2-1:0]    i_row,
    input  logic [LANES*2-1:0]    i_sym,
    input  logic [USER_CNT_W-1:0] i_users,
    output logic [SUM_W-1:0]      o_sum
);

    always_comb begin
        logic [SUM_W-1:0] acc;
        logic [1:0]       prod;
        acc = '0;
        for (int l = 0; l < LANES; l++) begin
            prod = trit_mul(i_row[2*l +: 2], i_sym[2*l +: 2]);
            if (USER_CNT_W'(l) < i_users) begin
                acc = acc + {{(SUM_W-2){prod[1]}}, prod};
            end
        end
        o_sum = acc;
    end

endmodule

[design/cdma_chip_spreader.sv]
// CDMA chip spreader.
// i_in carries one beat per item. func 0 loads one code chip of one user into
// the code memory (one row per chip position, one lane per user) and gives no
// output; func 1 carries one symbol per user and produces code_length beats on
// o_out, chip_index 0 upward, last_chip set on the final one. chip_sum is the
// sum over the first user_count users of code chip times symbol. code_length
// is clamped to 1..ROWS and user_count to 1..LANES. i_cfg writes user_count
// (index 0) and code_length (index 1); always ready, write only while the
// block is idle. A load is a row read, then a merged row write-back. Each
// chip of a spread beat goes through a memory row read and the output
// register, one chip per cycle while o_out does not stall; no new item is
// taken until every chip is read and the read stage is empty.
// Reset clears the code table (per-row valid bits, no clearing pass), sets
// user_count 8 and code_length 16 and empties the pipeline.
// When o_out stalls, the output register holds, the read stage holds one chip
// and row reads pause until the receiver takes the beat.
module cdma_chip_spreader
    import ccs_pkg::*;
#(
    parameter int MAX_USERS = 8,
    parameter int MAX_CHIPS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ccs_in_if.sink    i_in,
    ccs_cfg_if.sink   i_cfg,
    ccs_out_if.source o_out
);

    localparam int LANES  = (MAX_USERS < SYM_FIELDS) ? MAX_USERS : SYM_FIELDS;
    localparam int ROWS   = (MAX_CHIPS < CHIP_LIMIT) ? MAX_CHIPS : CHIP_LIMIT;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int DATA_W = LANES * 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SPREAD
    } t_state;

    t_state                r_state,    n_state;
    logic [USER_CNT_W-1:0] r_user_cnt;
    logic [CODE_LEN_W-1:0] r_code_len;
    logic [ROW_W-1:0]      r_ld_row,   n_ld_row;
    logic [LANE_W-1:0]     r_ld_lane,  n_ld_lane;
    logic [1:0]            r_ld_val,   n_ld_val;
    logic [DATA_W-1:0]     r_sym,      n_sym;
    logic [CHIP_IDX_W-1:0] r_chip,     n_chip;
    logic [CHIP_IDX_W-1:0] r_last,     n_last;
    logic                  r_rd_vld,   n_rd_vld;
    logic [CHIP_IDX_W-1:0] r_rd_idx,   n_rd_idx;
    logic                  r_rd_last,  n_rd_last;
    logic                  r_out_vld,  n_out_vld;
    logic [CHIP_IDX_W-1:0] r_out_idx,  n_out_idx;
    logic [SUM_W-1:0]      r_out_sum,  n_out_sum;
    logic                  r_out_last, n_out_last;

    logic                  in_ready;
    logic                  in_acc;
    logic                  out_free;
    logic                  issue;
    logic                  load_ok;
    logic [USER_CNT_W-1:0] users_act;
    logic [CODE_LEN_W-1:0] chips_act;
    logic                  mem_rd_en;
    logic [ROW_W-1:0]      mem_rd_addr;
    logic [DATA_W-1:0]     mem_rd_data;
    logic                  mem_wr_en;
    logic [DATA_W-1:0]     mem_wr_data;
    logic [SUM_W-1:0]      chip_sum;
    logic [1:0]            sym_in [SYM_FIELDS];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_user_cnt <= USER_COUNT_RST;
            r_code_len <= CODE_LENGTH_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_USER_COUNT) begin
                r_user_cnt <= i_cfg.data[USER_CNT_W-1:0];
            end else if (i_cfg.index == CFG_CODE_LENGTH) begin
                r_code_len <= i_cfg.data[CODE_LEN_W-1:0];
            end
        end
    end

    always_comb begin
        if (r_user_cnt == '0) begin
            users_act = USER_CNT_W'(1);
        end else if (r_user_cnt > USER_CNT_W'(LANES)) begin
            users_act = USER_CNT_W'(LANES);
        end else begin
            users_act = r_user_cnt;
        end
        if (r_code_len == '0) begin
            chips_act = CODE_LEN_W'(1);
        end else if (r_code_len > CODE_LEN_W'(ROWS)) begin
            chips_act = CODE_LEN_W'(ROWS);
        end else begin
            chips_act = r_code_len;
        end
    end

    assign sym_in[0] = i_in.bit_0;
    assign sym_in[1] = i_in.bit_1;
    assign sym_in[2] = i_in.bit_2;
    assign sym_in[3] = i_in.bit_3;
    assign sym_in[4] = i_in.bit_4;
    assign sym_in[5] = i_in.bit_5;
    assign sym_in[6] = i_in.bit_6;
    assign sym_in[7] = i_in.bit_7;

    assign out_free = !r_out_vld || o_out.ready;
    assign in_ready = (r_state == ST_IDLE) && !r_rd_vld;
    assign in_acc   = i_in.valid && in_ready;
    assign issue    = (r_state == ST_SPREAD) && (!r_rd_vld || out_free);
    assign load_ok  = ({1'b0, i_in.code_user} < 4'(LANES))
                   && ({1'b0, i_in.code_chip} < 5'(ROWS));
    assign i_in.ready = in_ready;

    assign mem_rd_en   = issue || (in_acc && i_in.func == FUNC_LOAD);
    assign mem_rd_addr = issue ? r_chip[ROW_W-1:0] : i_in.code_chip[ROW_W-1:0];
    assign mem_wr_en   = (r_state == ST_LOAD);

    // replace one lane of the row just read
    always_comb begin
        mem_wr_data = mem_rd_data;
        for (int l = 0; l < LANES; l++) begin
            if (LANE_W'(l) == r_ld_lane) begin
                mem_wr_data[2*l +: 2] = r_ld_val;
            end
        end
    end

    ccs_code_mem #(
        .ROWS   (ROWS),
        .ROW_W  (ROW_W),
        .DATA_W (DATA_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_ld_row),
        .i_wr_data (mem_wr_data)
    );

    ccs_chip_sum #(
        .LANES (LANES)
    ) u_sum (
        .i_row   (mem_rd_data),
        .i_sym   (r_sym),
        .i_users (users_act),
        .o_sum   (chip_sum)
    );

    always_comb begin
        n_state    = r_state;
        n_ld_row   = r_ld_row;
        n_ld_lane  = r_ld_lane;
        n_ld_val   = r_ld_val;
        n_sym      = r_sym;
        n_chip     = r_chip;
        n_last     = r_last;
        n_rd_vld   = r_rd_vld;
        n_rd_idx   = r_rd_idx;
        n_rd_last  = r_rd_last;
        n_out_vld  = r_out_vld;
        n_out_idx  = r_out_idx;
        n_out_sum  = r_out_sum;
        n_out_last = r_out_last;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.func == FUNC_LOAD) begin
                        if (load_ok) begin
                            n_state = ST_LOAD;
                        end
                        n_ld_row  = i_in.code_chip[ROW_W-1:0];
                        n_ld_lane = i_in.code_user[LANE_W-1:0];
                        n_ld_val  = sat_trit(i_in.code_value);
                    end else begin
                        n_state = ST_SPREAD;
                        n_chip  = '0;
                        n_last  = CHIP_IDX_W'(chips_act - CODE_LEN_W'(1));
                        for (int l = 0; l < LANES; l++) begin
                            n_sym[2*l +: 2] = sat_trit(sym_in[l]);
                        end
                    end
                end
            end
            ST_LOAD: begin
                n_state = ST_IDLE;
            end
            ST_SPREAD: begin
                if (issue) begin
                    n_chip = r_chip + CHIP_IDX_W'(1);
                    if (r_chip == r_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (issue) begin
            n_rd_vld  = 1'b1;
            n_rd_idx  = r_chip;
            n_rd_last = (r_chip == r_last);
        end else if (r_rd_vld && out_free) begin
            n_rd_vld = 1'b0;
        end

        if (r_rd_vld && out_free) begin
            n_out_vld  = 1'b1;
            n_out_idx  = r_rd_idx;
            n_out_sum  = chip_sum;
            n_out_last = r_rd_last;
        end else if (o_out.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
        r_ld_row   <= n_ld_row;
        r_ld_lane  <= n_ld_lane;
        r_ld_val   <= n_ld_val;
        r_sym      <= n_sym;
        r_chip     <= n_chip;
        r_last     <= n_last;
        r_rd_idx   <= n_rd_idx;
        r_rd_last  <= n_rd_last;
        r_out_idx  <= n_out_idx;
        r_out_sum  <= n_out_sum;
        r_out_last <= n_out_last;
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.chip_index = r_out_idx;
    assign o_out.chip_sum   = r_out_sum;
    assign o_out.last_chip  = r_out_last;

endmodule

[design/ccs_chk.sv]
module ccs_chk
    import ccs_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_in_func,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [CHIP_IDX_W-1:0] i_out_chip_index,
    input logic [SUM_W-1:0]      i_out_chip_sum,
    input logic                  i_out_last_chip
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_chip_index) && $stable(i_out_chip_sum)
            && $stable(i_out_last_chip))
        else $error("output beat changed while stalled");

    a_busy_mid_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last_chip |-> !i_in_ready)
        else $error("input taken before symbol finished");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_func == FUNC_LOAD && !i_out_valid
            |=> !i_out_valid)
        else $error("load beat produced output");

    a_first_chip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_func == FUNC_SPREAD && !i_out_valid
            |-> ##3 (i_out_valid && i_out_chip_index == '0))
        else $error("first chip missing or misnumbered");

endmodule

bind cdma_chip_spreader ccs_chk u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_func        (i_in.func),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_chip_index (o_out.chip_index),
    .i_out_chip_sum   (o_out.chip_sum),
    .i_out_last_chip  (o_out.last_chip)
);
